/* rtl/bph_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bph_pkg;

   // Request actions, as carried on req_tuser.
   localparam logic [1:0] ACT_BYTE   = 2'd0;
   localparam logic [1:0] ACT_THRESH = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // Commands passed from the parser to the table engine.
   localparam logic [1:0] OP_COUNT  = 2'd0;
   localparam logic [1:0] OP_THRESH = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // Result kinds, as carried on rsp_tuser.
   localparam logic [1:0] KIND_QUERY  = 2'd0;
   localparam logic [1:0] KIND_THRESH = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // Configuration register indexes.
   localparam logic [7:0] CSR_RANK_INDEX = 8'd0;
   localparam logic [7:0] CSR_MIN_LENGTH = 8'd1;

   localparam logic [15:0] RANK_RESET    = 16'd13107;
   localparam logic [7:0]  MIN_LEN_RESET = 8'd54;

   // Protocol constants.
   localparam logic [15:0] ETH_IPV4  = 16'h0800;
   localparam logic [15:0] ETH_VLAN  = 16'h8100;
   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [4:0]  IP_START_PLAIN = 5'd14;
   localparam logic [4:0]  IP_START_VLAN  = 5'd18;

   localparam int PAIR_INDEX_WIDTH = 16;
   localparam int RESULT_WIDTH     = 32;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_WIDTH  = 2;

   typedef struct packed {
      logic [1:0]                  op;
      logic [PAIR_INDEX_WIDTH-1:0] index;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } engine_status_type;

endpackage

`default_nettype wire

/* rtl/bph_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module bph_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [1:0]                  in_action,
   input  wire logic [7:0]                  in_byte,
   input  wire logic [15:0]                 in_flen,
   input  wire logic                        in_last,
   input  wire logic [7:0]                  in_first,
   input  wire logic [7:0]                  in_second,
   input  wire logic [7:0]                  min_len,
   input  wire bph_pkg::engine_status_type  status,
   input  wire logic                        queue_full,
   output logic                             push,
   output bph_pkg::cmd_type                 push_cmd
);

   logic [15:0] off_ff, off_in;
   logic [4:0]  ips_ff, ips_in;
   logic [5:0]  ihb_ff, ihb_in;
   logic [15:0] tot_ff, tot_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] ps_ff, ps_in;
   logic [15:0] pe_ff, pe_in;
   logic [7:0]  prev_ff, prev_in;
   logic        acc_ff, acc_in;
   logic [7:0]  eth_ff, eth_in;
   logic        take;
   logic        emit;

   assign in_ready = !queue_full && !status.init_busy;
   assign take     = in_valid && in_ready;

   // Header parser and payload pair extraction for one frame word.
   always_comb begin
      logic [15:0] r;
      logic [16:0] e;
      logic [5:0]  th;
      logic        cnt;
      off_in   = off_ff;
      ips_in   = ips_ff;
      ihb_in   = ihb_ff;
      tot_in   = tot_ff;
      proto_in = proto_ff;
      ps_in    = ps_ff;
      pe_in    = pe_ff;
      prev_in  = prev_ff;
      acc_in   = acc_ff;
      eth_in   = eth_ff;
      emit     = 1'b0;
      r        = off_ff - {11'd0, ips_ff};
      e        = {12'd0, ips_ff} + {1'b0, tot_ff[15:8], in_byte};
      th       = {in_byte[7:4], 2'b00};
      if (off_ff == 16'd0) begin
         acc_in = (in_flen >= {8'd0, min_len});
      end
      if (acc_in) begin
         if (off_ff == 16'd12) begin
            eth_in = in_byte;
         end else if (off_ff == 16'd13) begin
            if ({eth_ff, in_byte} == bph_pkg::ETH_IPV4) begin
               ips_in = bph_pkg::IP_START_PLAIN;
            end else if ({eth_ff, in_byte} == bph_pkg::ETH_VLAN) begin
               ips_in = bph_pkg::IP_START_VLAN;
            end else begin
               acc_in = 1'b0;
            end
         end else if (ips_ff == bph_pkg::IP_START_VLAN && off_ff == 16'd16) begin
            eth_in = in_byte;
         end else if (ips_ff == bph_pkg::IP_START_VLAN && off_ff == 16'd17) begin
            if ({eth_ff, in_byte} != bph_pkg::ETH_IPV4) begin
               acc_in = 1'b0;
            end
         end else if (off_ff >= 16'd14 && off_ff >= {11'd0, ips_ff}) begin
            if (r == 16'd0) begin
               ihb_in = {in_byte[3:0], 2'b00};
               if (in_byte[7:4] != 4'd4 || {in_byte[3:0], 2'b00} < 6'd20) begin
                  acc_in = 1'b0;
               end
            end else if (r == 16'd2) begin
               tot_in = {in_byte, 8'd0};
            end else if (r == 16'd3) begin
               tot_in = {tot_ff[15:8], in_byte};
               pe_in  = e[16] ? 16'hFFFF : e[15:0];
            end else if (r == 16'd9) begin
               proto_in = in_byte;
               if (in_byte == bph_pkg::PROTO_UDP) begin
                  ps_in = {11'd0, ips_ff} + {10'd0, ihb_ff} + 16'd8;
               end else if (in_byte != bph_pkg::PROTO_TCP) begin
                  acc_in = 1'b0;
               end
            end else if (proto_ff == bph_pkg::PROTO_TCP &&
                         r == {10'd0, ihb_ff} + 16'd12) begin
               if (th < 6'd20) begin
                  acc_in = 1'b0;
               end else begin
                  ps_in = {11'd0, ips_ff} + {10'd0, ihb_ff} + {10'd0, th};
               end
            end
         end
      end
      // Payload bytes: every byte after the first forms a pair with the one before.
      cnt = acc_in && ps_in != 16'd0 && off_ff >= ps_in && off_ff < pe_in &&
            off_ff < in_flen;
      if (cnt) begin
         emit    = (off_ff > ps_in);
         prev_in = in_byte;
      end
      if (in_last) begin
         off_in   = 16'd0;
         ips_in   = bph_pkg::IP_START_PLAIN;
         ihb_in   = 6'd0;
         tot_in   = 16'd0;
         proto_in = 8'd0;
         ps_in    = 16'd0;
         pe_in    = 16'd0;
         prev_in  = 8'd0;
         acc_in   = 1'b0;
         eth_in   = 8'd0;
      end else if (off_ff != 16'hFFFF) begin
         off_in = off_ff + 16'd1;
      end
   end

   // Command toward the table engine.
   always_comb begin
      push           = 1'b0;
      push_cmd.op    = bph_pkg::OP_COUNT;
      push_cmd.index = {prev_ff, in_byte};
      if (take) begin
         case (in_action)
            bph_pkg::ACT_BYTE: begin
               push = emit;
            end
            bph_pkg::ACT_THRESH: begin
               push        = 1'b1;
               push_cmd.op = bph_pkg::OP_THRESH;
            end
            bph_pkg::ACT_QUERY: begin
               push           = 1'b1;
               push_cmd.op    = bph_pkg::OP_QUERY;
               push_cmd.index = {in_first, in_second};
            end
            default: begin
               push        = 1'b1;
               push_cmd.op = bph_pkg::OP_CLEAR;
            end
         endcase
      end
   end

   // Parser state advances on frame words only.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= 16'd0;
         ips_ff   <= bph_pkg::IP_START_PLAIN;
         ihb_ff   <= 6'd0;
         tot_ff   <= 16'd0;
         proto_ff <= 8'd0;
         ps_ff    <= 16'd0;
         pe_ff    <= 16'd0;
         prev_ff  <= 8'd0;
         acc_ff   <= 1'b0;
         eth_ff   <= 8'd0;
      end else if (take && in_action == bph_pkg::ACT_BYTE) begin
         off_ff   <= off_in;
         ips_ff   <= ips_in;
         ihb_ff   <= ihb_in;
         tot_ff   <= tot_in;
         proto_ff <= proto_in;
         ps_ff    <= ps_in;
         pe_ff    <= pe_in;
         prev_ff  <= prev_in;
         acc_ff   <= acc_in;
         eth_ff   <= eth_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/bph_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module bph_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bph_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output bph_pkg::cmd_type      head
);

   bph_pkg::cmd_type                     entry_ff [bph_pkg::QUEUE_DEPTH];
   logic [bph_pkg::QUEUE_PTR_WIDTH-1:0] wptr_ff, wptr_in;
   logic [bph_pkg::QUEUE_PTR_WIDTH-1:0] rptr_ff, rptr_in;
   logic [bph_pkg::QUEUE_PTR_WIDTH:0]   fill_ff, fill_in;

   assign full      = (fill_ff == (bph_pkg::QUEUE_PTR_WIDTH+1)'(bph_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = entry_ff[rptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/bph_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module bph_engine #(
   parameter int COUNT_WIDTH      = 32,
   parameter int PAIR_TABLE_DEPTH = 65536
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  wire bph_pkg::cmd_type                 cmd,
   output logic                                  cmd_pop,
   output bph_pkg::engine_status_type            status,
   input  wire logic [15:0]                      rank,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic [1:0]                            out_kind,
   output logic [bph_pkg::RESULT_WIDTH-1:0]      out_count,
   output logic                                  out_marked,
   output logic [bph_pkg::RESULT_WIDTH-1:0]      out_threshold
);

   localparam int AW = $clog2(PAIR_TABLE_DEPTH);
   localparam int CW = COUNT_WIDTH;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_INCR  = 3'd2;
   localparam logic [2:0] ST_QUERY = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_STEP  = 3'd6;
   localparam logic [2:0] ST_CLEAR = 3'd7;

   logic [CW-1:0] table_mem [PAIR_TABLE_DEPTH];

   logic [2:0]    state_ff, state_in;
   logic          resp_ff, resp_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW:0]   tally_ff, tally_in;
   logic [CW:0]   low_ff, low_in;
   logic [CW:0]   high_ff, high_in;
   logic [CW:0]   mid_ff, mid_in;
   logic [CW-1:0] thr_ff, thr_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0] rd_data_ff;
   logic [1:0]    res_kind_ff, res_kind_in;
   logic [CW-1:0] res_count_ff, res_count_in;
   logic          res_mark_ff, res_mark_in;
   logic          out_vld_ff;
   logic [1:0]    out_kind_ff;
   logic [CW-1:0] out_count_ff;
   logic          out_mark_ff;
   logic [CW-1:0] out_thr_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [CW-1:0] mem_wdata;
   logic [AW-1:0] rd_addr;
   logic          load_out;

   assign status.init_busy = (state_ff == ST_INIT);
   assign load_out         = resp_ff && (!out_vld_ff || out_ready);

   // Sequencer of the table operations.
   always_comb begin
      logic [CW:0] nl;
      logic [CW:0] nh;
      state_in     = state_ff;
      resp_in      = resp_ff && !load_out;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      thr_in       = thr_ff;
      cmp_vld_in   = 1'b0;
      res_kind_in  = res_kind_ff;
      res_count_in = res_count_ff;
      res_mark_in  = res_mark_ff;
      mem_we       = 1'b0;
      mem_waddr    = scan_ff;
      mem_wdata    = '0;
      rd_addr      = cmd.index[AW-1:0];
      cmd_pop      = 1'b0;
      tally_in     = tally_ff;
      nl           = low_ff;
      nh           = high_ff;
      // Scan compare, one read word per cycle.
      if (cmp_vld_ff && {1'b0, rd_data_ff} >= mid_ff) begin
         tally_in = tally_ff + 1'b1;
      end
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_we  = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == '1) begin
               if (state_ff == ST_CLEAR) begin
                  res_kind_in  = bph_pkg::KIND_CLEAR;
                  res_count_in = '0;
                  res_mark_in  = 1'b0;
                  resp_in      = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && !resp_ff) begin
               cmd_pop = 1'b1;
               idx_in  = cmd.index[AW-1:0];
               case (cmd.op)
                  bph_pkg::OP_COUNT: begin
                     state_in = ST_INCR;
                  end
                  bph_pkg::OP_QUERY: begin
                     state_in = ST_QUERY;
                  end
                  bph_pkg::OP_THRESH: begin
                     low_in   = '0;
                     high_in  = {1'b1, {CW{1'b0}}};
                     mid_in   = {2'b01, {(CW-1){1'b0}}};
                     tally_in = '0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     scan_in  = '0;
                     state_in = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_INCR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
            state_in  = ST_IDLE;
         end
         ST_QUERY: begin
            res_kind_in  = bph_pkg::KIND_QUERY;
            res_count_in = rd_data_ff;
            res_mark_in  = (rd_data_ff >= thr_ff);
            resp_in      = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            rd_addr    = scan_ff;
            cmp_vld_in = 1'b1;
            scan_in    = scan_ff + 1'b1;
            if (scan_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_STEP;
         end
         default: begin
            // Halve the search interval from the completed tally.
            if (tally_ff > {1'b0, rank}) begin
               nl = mid_ff;
            end else begin
               nh = mid_ff;
            end
            low_in   = nl;
            high_in  = nh;
            tally_in = '0;
            scan_in  = '0;
            if (nh - nl > (CW+1)'(1)) begin
               mid_in   = nl + ((nh - nl) >> 1);
               state_in = ST_SCAN;
            end else begin
               thr_in       = nl[CW-1:0];
               res_kind_in  = bph_pkg::KIND_THRESH;
               res_count_in = '0;
               res_mark_in  = 1'b0;
               resp_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         resp_ff    <= 1'b0;
         scan_ff    <= '0;
         tally_ff   <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         thr_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         resp_ff    <= resp_in;
         scan_ff    <= scan_in;
         tally_ff   <= tally_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         thr_ff     <= thr_in;
         cmp_vld_ff <= cmp_vld_in;
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end else if (out_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      mid_ff       <= mid_in;
      res_kind_ff  <= res_kind_in;
      res_count_ff <= res_count_in;
      res_mark_ff  <= res_mark_in;
      if (load_out) begin
         out_kind_ff  <= res_kind_ff;
         out_count_ff <= res_count_ff;
         out_mark_ff  <= res_mark_ff;
         out_thr_ff   <= thr_ff;
      end
   end

   // Count table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign out_valid     = out_vld_ff;
   assign out_kind      = out_kind_ff;
   assign out_count     = bph_pkg::RESULT_WIDTH'(out_count_ff);
   assign out_marked    = out_mark_ff;
   assign out_threshold = bph_pkg::RESULT_WIDTH'(out_thr_ff);

`ifndef SYNTH
   // No command is taken while the table is being cleared after reset.
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !cmd_pop)
      else $error("command taken during initial clear");

   // The search interval never collapses while a scan is running.
   a_interval_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_STEP) |-> (high_ff > low_ff + 1'b1))
      else $error("threshold search interval collapsed");

   // A result kind on the output is one of the defined kinds.
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_kind_ff == bph_pkg::KIND_QUERY ||
                      out_kind_ff == bph_pkg::KIND_THRESH ||
                      out_kind_ff == bph_pkg::KIND_CLEAR))
      else $error("undefined result kind");

   // The tally never exceeds the table depth.
   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= (AW+1)'(PAIR_TABLE_DEPTH))
      else $error("scan tally overflow");
`endif

endmodule

`default_nettype wire

/* rtl/payload_byte_pair_histogram_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Contents
// req       in         req_tvalid/tready    frame word, threshold, query or clear
// rsp       out        rsp_tvalid/tready    query answer, threshold done, clear done
// csr       in         csr_valid/ready      register index and write data
//
// The parser takes one frame word per cycle while its 4-entry command queue has room
// and the reset clear is done. A pair count is a read and a write of the table memory.
// A query answer goes through the result and output registers; a clear zeroes the table.
// A threshold runs COUNT_WIDTH scans of 65536 reads.
// After reset the table is cleared, and req_tready stays low until that is done.
// A stalled result waits in the output register while the queue keeps filling.
module payload_byte_pair_histogram_unit #(
   parameter int COUNT_WIDTH      = 32,
   parameter int PAIR_TABLE_DEPTH = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // data_byte, frame_length, first_byte, second_byte
   input  wire logic [1:0]  req_tuser,  // action
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // pair_count, pair_marked, threshold_value, zeros
   output logic [1:0]       rsp_tuser,  // result_kind
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   logic [15:0]                    rank_ff;
   logic [7:0]                     min_len_ff;
   bph_pkg::engine_status_type     status;
   bph_pkg::cmd_type               push_cmd;
   bph_pkg::cmd_type               head;
   logic                           push;
   logic                           pop;
   logic                           full;
   logic                           not_empty;
   logic [bph_pkg::RESULT_WIDTH-1:0] count;
   logic [bph_pkg::RESULT_WIDTH-1:0] threshold;
   logic                           marked;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= bph_pkg::RANK_RESET;
         min_len_ff <= bph_pkg::MIN_LEN_RESET;
      end else if (csr_valid) begin
         if (csr_index == bph_pkg::CSR_RANK_INDEX) begin
            rank_ff <= csr_data;
         end else if (csr_index == bph_pkg::CSR_MIN_LENGTH) begin
            min_len_ff <= csr_data[7:0];
         end
      end
   end

   bph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_byte    (req_tdata[7:0]),
      .in_flen    (req_tdata[23:8]),
      .in_last    (req_tlast),
      .in_first   (req_tdata[31:24]),
      .in_second  (req_tdata[39:32]),
      .min_len    (min_len_ff),
      .status     (status),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   bph_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   bph_engine #(
      .COUNT_WIDTH      (COUNT_WIDTH),
      .PAIR_TABLE_DEPTH (PAIR_TABLE_DEPTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (not_empty),
      .cmd           (head),
      .cmd_pop       (pop),
      .status        (status),
      .rank          (rank_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_kind      (rsp_tuser),
      .out_count     (count),
      .out_marked    (marked),
      .out_threshold (threshold)
   );

   assign rsp_tdata = {7'd0, threshold, marked, count};

endmodule

`default_nettype wire

/* sim/tb_payload_byte_pair_histogram_unit.sv */
`timescale 1ns / 1ps

// One expected result word.
typedef struct {
   logic [1:0]  kind;
   logic [31:0] count;
   logic        marked;
   logic [31:0] threshold;
} pair_result_type;

// Tracks the pair table and the frame parser, and checks every result word.
class pair_histogram_scoreboard;
   int unsigned pair_tally[int unsigned];
   int unsigned threshold;
   int unsigned rank_reg;
   int unsigned min_len_reg;
   int unsigned offset;
   int unsigned ip_base;
   int unsigned ip_hdr_len;
   int unsigned ip_total;
   int unsigned l4_proto;
   int unsigned pay_first;
   int unsigned pay_stop;
   int unsigned prev_byte;
   int unsigned type_high;
   bit          accepted;
   pair_result_type pending_results[$];
   int          errors;
   int          results_seen;
   int          frames_seen;
   int          thresholds_seen;

   function new();
      threshold = 0;
      rank_reg = 32'(bph_pkg::RANK_RESET);
      min_len_reg = 32'(bph_pkg::MIN_LEN_RESET);
      errors = 0;
      results_seen = 0;
      frames_seen = 0;
      thresholds_seen = 0;
      restart_frame();
   endfunction

   function void restart_frame();
      offset = 0;
      ip_base = 32'(bph_pkg::IP_START_PLAIN);
      ip_hdr_len = 0;
      ip_total = 0;
      l4_proto = 0;
      pay_first = 0;
      pay_stop = 0;
      prev_byte = 0;
      accepted = 0;
      type_high = 0;
   endfunction

   function void write_register(logic [7:0] index, logic [15:0] value);
      if (index == bph_pkg::CSR_RANK_INDEX) begin
         rank_reg = 32'(value);
      end else if (index == bph_pkg::CSR_MIN_LENGTH) begin
         min_len_reg = 32'(value[7:0]);
      end
   endfunction

   // Header parsing for one accepted frame byte.
   function void parse_header(int unsigned b);
      int unsigned rel;
      int unsigned stop;
      int unsigned tcp_len;
      if (offset == 12) begin
         type_high = b;
         return;
      end
      if (offset == 13) begin
         if (((type_high << 8) | b) == bph_pkg::ETH_IPV4) begin
            ip_base = 32'(bph_pkg::IP_START_PLAIN);
         end else if (((type_high << 8) | b) == bph_pkg::ETH_VLAN) begin
            ip_base = 32'(bph_pkg::IP_START_VLAN);
         end else begin
            accepted = 0;
         end
         return;
      end
      if (ip_base == bph_pkg::IP_START_VLAN && offset == 16) begin
         type_high = b;
         return;
      end
      if (ip_base == bph_pkg::IP_START_VLAN && offset == 17) begin
         if (((type_high << 8) | b) != bph_pkg::ETH_IPV4) accepted = 0;
         return;
      end
      if (offset < 14 || offset < ip_base) return;
      rel = offset - ip_base;
      if (rel == 0) begin
         ip_hdr_len = (b & 15) * 4;
         if ((b >> 4) != 4 || ip_hdr_len < 20) accepted = 0;
      end else if (rel == 2) begin
         ip_total = b << 8;
      end else if (rel == 3) begin
         ip_total = ip_total | b;
         stop = ip_base + ip_total;
         pay_stop = (stop > 65535) ? 65535 : stop;
      end else if (rel == 9) begin
         l4_proto = b;
         if (b == bph_pkg::PROTO_UDP) begin
            pay_first = ip_base + ip_hdr_len + 8;
         end else if (b != bph_pkg::PROTO_TCP) begin
            accepted = 0;
         end
      end else if (l4_proto == bph_pkg::PROTO_TCP && rel == ip_hdr_len + 12) begin
         tcp_len = (b >> 4) * 4;
         if (tcp_len < 20) begin
            accepted = 0;
         end else begin
            pay_first = ip_base + ip_hdr_len + tcp_len;
         end
      end
   endfunction

   function int unsigned tally_of(int unsigned idx);
      return pair_tally.exists(idx) ? pair_tally[idx] : 0;
   endfunction

   // Count at the configured descending rank; untouched entries are zero.
   function int unsigned rank_count();
      int unsigned counts[$];
      foreach (pair_tally[k]) counts.push_back(pair_tally[k]);
      counts.rsort();
      return (rank_reg < counts.size()) ? counts[rank_reg] : 0;
   endfunction

   // Called for every accepted request word.
   function void note_request(logic [1:0] action, logic [7:0] data, logic [15:0] flen,
                              logic last, logic [7:0] first, logic [7:0] second);
      pair_result_type res;
      int unsigned idx;
      if (action == bph_pkg::ACT_BYTE) begin
         if (offset == 0) accepted = (flen >= min_len_reg);
         if (accepted) parse_header(32'(data));
         if (accepted && pay_first != 0 && offset >= pay_first && offset < pay_stop &&
             offset < flen) begin
            if (offset > pay_first) begin
               idx = (prev_byte << 8) | 32'(data);
               if (tally_of(idx) != 32'hFFFF_FFFF) pair_tally[idx] = tally_of(idx) + 1;
            end
            prev_byte = 32'(data);
         end
         if (last) begin
            restart_frame();
            frames_seen++;
         end else if (offset < 65535) begin
            offset++;
         end
         return;
      end
      res.count = 0;
      res.marked = 0;
      if (action == bph_pkg::ACT_THRESH) begin
         threshold = rank_count();
         thresholds_seen++;
         res.kind = bph_pkg::KIND_THRESH;
      end else if (action == bph_pkg::ACT_QUERY) begin
         res.kind = bph_pkg::KIND_QUERY;
         res.count = tally_of(32'({first, second}));
         res.marked = (res.count >= threshold);
      end else begin
         pair_tally.delete();
         res.kind = bph_pkg::KIND_CLEAR;
      end
      res.threshold = threshold;
      pending_results.push_back(res);
   endfunction

   // Called for every accepted result word.
   function void check_result(logic [1:0] kind, logic [31:0] count, logic marked,
                              logic [31:0] thr);
      pair_result_type want;
      results_seen++;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result word kind %0d count %0d", $time, kind, count);
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind) begin
         $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
         errors++;
      end
      if (count !== want.count) begin
         $display("%0t: pair count expected %0d actual %0d", $time, want.count, count);
         errors++;
      end
      if (marked !== want.marked) begin
         $display("%0t: marked expected %0d actual %0d", $time, want.marked, marked);
         errors++;
      end
      if (thr !== want.threshold) begin
         $display("%0t: threshold expected %0d actual %0d", $time, want.threshold, thr);
         errors++;
      end
   endfunction
endclass

module tb_payload_byte_pair_histogram_unit;

   localparam longint CYCLE_LIMIT = 40_000_000;

   // Frame flavors built by the stimulus.
   localparam int FR_GOOD       = 0;
   localparam int FR_BAD_TYPE   = 1;
   localparam int FR_BAD_INNER  = 2;
   localparam int FR_BAD_VER    = 3;
   localparam int FR_SHORT_IHL  = 4;
   localparam int FR_BAD_PROTO  = 5;
   localparam int FR_SHORT_DOFF = 6;
   localparam int FR_SHORT_TOT  = 7;
   localparam int FR_TRUNCATED  = 8;
   localparam int FR_NOISE      = 9;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;  // data_byte, frame_length, first_byte, second_byte
   logic [1:0]  req_tuser;  // action
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;  // pair_count, pair_marked, threshold_value, zeros
   logic [1:0]  rsp_tuser;  // result_kind
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   pair_histogram_scoreboard sb = new();
   longint cycles = 0;
   int     burst_left = 0;
   int unsigned words_sent = 0;
   bit     no_gaps = 0;
   bit     hold_request = 0;
   logic [7:0] alphabet [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

   payload_byte_pair_histogram_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
   end

   // Monitors sample the values that were present before the edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_request(req_tuser, req_tdata[7:0], req_tdata[23:8], req_tlast,
                         req_tdata[31:24], req_tdata[39:32]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[64:33]);
      end
   end

   // Receiver: stall modes that change every so often, plus one long hold-off.
   initial begin
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      rsp_tready <= 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_request = 0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_tready <= 1;
               end
               1: begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one request word and wait for it to be taken; then maybe pause.
   task automatic send_word(logic [1:0] action, logic [7:0] data, logic [15:0] flen,
                            logic last, logic [15:0] pair);
      int gap;
      req_tvalid <= 1;
      req_tuser <= action;
      req_tlast <= last;
      req_tdata <= {pair, flen, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_query(logic [7:0] first, logic [7:0] second);
      send_word(bph_pkg::ACT_QUERY, rand_byte(), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), {second, first});
   endtask

   task automatic send_action(logic [1:0] action);
      send_word(action, rand_byte(), 16'($urandom_range(0, 65535)),
                1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
   endtask

   function automatic logic [7:0] payload_byte();
      return ($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 3)] : rand_byte();
   endfunction

   // Builds one frame of the given flavor; flen is the length sent with its bytes.
   task automatic build_frame(int flavor, ref logic [7:0] fr[$], ref int unsigned flen);
      bit vlan;
      bit udp;
      int ihl;
      int doff;
      int pay_len;
      int l4_len;
      int unsigned tot;
      fr.delete();
      vlan = 1'($urandom_range(0, 1));
      udp = 1'($urandom_range(0, 1));
      if (flavor == FR_BAD_INNER) vlan = 1;
      if (flavor == FR_SHORT_DOFF) udp = 0;
      ihl = (flavor == FR_SHORT_IHL) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      doff = (flavor == FR_SHORT_DOFF) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      pay_len = $urandom_range(0, 24);
      if (flavor == FR_NOISE) begin
         repeat ($urandom_range(1, 80)) fr.push_back(rand_byte());
         flen = $urandom_range(0, 1) ? fr.size() : $urandom_range(0, 65535);
         return;
      end
      repeat (12) fr.push_back(rand_byte());
      if (flavor == FR_BAD_TYPE) begin
         fr.push_back(rand_byte());
         fr.push_back(rand_byte());
      end else if (vlan) begin
         fr.push_back(bph_pkg::ETH_VLAN[15:8]);
         fr.push_back(bph_pkg::ETH_VLAN[7:0]);
         fr.push_back(rand_byte());
         fr.push_back(rand_byte());
      end
      if (flavor == FR_BAD_INNER) begin
         fr.push_back(rand_byte());
         fr.push_back(8'($urandom_range(1, 255)));
      end else if (flavor != FR_BAD_TYPE) begin
         fr.push_back(bph_pkg::ETH_IPV4[15:8]);
         fr.push_back(bph_pkg::ETH_IPV4[7:0]);
      end
      l4_len = udp ? 8 : doff * 4;
      if (l4_len < 20) l4_len = 20;
      tot = ((ihl < 5) ? 20 : ihl * 4) + l4_len + pay_len;
      if (flavor == FR_SHORT_TOT) tot = $urandom_range(0, tot - pay_len);
      else if ($urandom_range(0, 5) == 0) tot = $urandom_range(0, 65535);
      fr.push_back((flavor == FR_BAD_VER) ? {4'($urandom_range(5, 15)), 4'(ihl)}
                                          : {4'd4, 4'(ihl)});
      fr.push_back(rand_byte());
      fr.push_back(tot[15:8]);
      fr.push_back(tot[7:0]);
      repeat (5) fr.push_back(rand_byte());
      if (flavor == FR_BAD_PROTO) fr.push_back(8'($urandom_range(18, 255)));
      else fr.push_back(udp ? bph_pkg::PROTO_UDP : bph_pkg::PROTO_TCP);
      repeat (10) fr.push_back(rand_byte());
      if (ihl > 5) repeat ((ihl - 5) * 4) fr.push_back(rand_byte());
      if (udp) begin
         repeat (8) fr.push_back(rand_byte());
      end else begin
         repeat (12) fr.push_back(rand_byte());
         fr.push_back({4'(doff), 4'($urandom_range(0, 15))});
         repeat (7) fr.push_back(rand_byte());
         if (doff > 5) repeat ((doff - 5) * 4) fr.push_back(rand_byte());
      end
      repeat (pay_len) fr.push_back(payload_byte());
      flen = fr.size();
      if (flavor == FR_TRUNCATED) flen = $urandom_range(0, fr.size());
      else if ($urandom_range(0, 7) == 0) flen = fr.size() + $urandom_range(1, 300);
   endtask

   // Sends a frame, now and then slipping a query between its bytes.
   task automatic send_frame(int flavor);
      logic [7:0] fr[$];
      int unsigned flen;
      build_frame(flavor, fr, flen);
      foreach (fr[i]) begin
         send_word(bph_pkg::ACT_BYTE, fr[i], flen[15:0], i == fr.size() - 1,
                   16'($urandom_range(0, 65535)));
         if ($urandom_range(0, 60) == 0) begin
            send_query(alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)]);
         end
      end
   endtask

   // Drop valid, let every expected result come back, then let the pipe drain.
   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] index, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic query_some(int n);
      repeat (n) begin
         if ($urandom_range(0, 3) != 0) begin
            send_query(alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)]);
         end else begin
            send_query(rand_byte(), rand_byte());
         end
      end
   endtask

   initial begin
      logic [7:0] fr[$];
      int flavor;
      int unsigned flen_built;
      reset <= 1;
      req_tvalid <= 0;
      req_tdata <= '0;
      req_tuser <= bph_pkg::ACT_BYTE;
      req_tlast <= 0;
      csr_valid <= 0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at reset settings: every frame flavor and the extreme pairs.
      for (int f = FR_GOOD; f <= FR_NOISE; f++) send_frame(f);
      send_query(8'h00, 8'h00);
      send_query(8'hFF, 8'hFF);
      wait_idle();

      // Rank index zero, every frame accepted, one frame with the largest lengths.
      write_csr(bph_pkg::CSR_RANK_INDEX, 16'd0);
      write_csr(bph_pkg::CSR_MIN_LENGTH, 16'd0);
      no_gaps = 1;
      build_frame(FR_GOOD, fr, flen_built);
      fr = fr[0:41];
      fr[16] = 8'hFF;
      fr[17] = 8'hFF;
      fr[14] = {4'd4, 4'd5};
      fr[12] = bph_pkg::ETH_IPV4[15:8];
      fr[13] = bph_pkg::ETH_IPV4[7:0];
      fr[23] = bph_pkg::PROTO_UDP;
      while (fr.size() < 64) fr.push_back(payload_byte());
      foreach (fr[i]) begin
         send_word(bph_pkg::ACT_BYTE, fr[i], 16'hFFFF, i == fr.size() - 1,
                   16'($urandom_range(0, 65535)));
      end
      no_gaps = 0;

      // Receiver holds off while queries keep coming, so the input backs up.
      hold_request = 1;
      query_some(16);
      send_action(bph_pkg::ACT_THRESH);
      query_some(12);
      send_action(bph_pkg::ACT_CLEAR);
      query_some(4);
      wait_idle();

      // Random part: mostly well-formed frames, with broken ones and noise mixed in.
      write_csr(bph_pkg::CSR_RANK_INDEX, 16'($urandom_range(1, 12)));
      write_csr(bph_pkg::CSR_MIN_LENGTH, 16'($urandom_range(20, 80)));
      while (words_sent < 680) begin
         flavor = ($urandom_range(0, 9) < 7) ? FR_GOOD : $urandom_range(FR_BAD_TYPE, FR_NOISE);
         send_frame(flavor);
         if ($urandom_range(0, 3) == 0) begin
            query_some($urandom_range(1, 6));
         end
      end
      send_action(bph_pkg::ACT_THRESH);
      query_some(40);
      wait_idle();

      // Opposite extremes of both registers.
      write_csr(bph_pkg::CSR_RANK_INDEX, 16'hFFFF);
      write_csr(bph_pkg::CSR_MIN_LENGTH, 16'h00FF);
      send_frame(FR_GOOD);
      query_some(10);
      send_action(bph_pkg::ACT_CLEAR);
      query_some(6);
      wait_idle();
      repeat (100) @(posedge clock);

      $display("Covered %0d frames, %0d request words, %0d result words and %0d searches.",
               sb.frames_seen, words_sent, sb.results_seen, sb.thresholds_seen);
      $display("Mismatches found: %0d", sb.errors);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
